// ----- sv/bdw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bdw_pkg;

   localparam int COORD_W    = 5;
   localparam int COORD_SPAN = 1 << COORD_W;
   localparam int HALF_W     = COORD_W - 1;
   localparam int PIXEL_W    = 16;
   localparam int SHIFT_W    = 16;
   localparam int FRAC_W     = 8;
   localparam int WEIGHT_W   = FRAC_W + 1;
   localparam int GRID_W     = 6;
   localparam int SIZE_W     = 9;
   localparam int BASE_W     = 10;
   localparam int HSUM_W     = PIXEL_W + WEIGHT_W;
   localparam int VSUM_W     = 32;
   localparam int BANKS      = 4;

   localparam int DEFAULT_MAX_ROWS = 32;
   localparam int DEFAULT_MAX_COLS = 32;

   localparam logic [GRID_W-1:0]          GRID_RESET = 6'd29;
   localparam logic signed [PIXEL_W-1:0]  BACKGROUND = -16'sd16384;
   localparam logic [WEIGHT_W-1:0]        ONE_Q8     = 9'd256;
   localparam logic [VSUM_W-1:0]          ROUND_HALF = 32'h0000_8000;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLS = 1'b1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_WARP = 1'b1;

   typedef struct packed {
      logic                bg;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic                row_par;
      logic                col_par;
      logic [WEIGHT_W-1:0] wr0;
      logic [WEIGHT_W-1:0] wr1;
      logic [WEIGHT_W-1:0] wc0;
      logic [WEIGHT_W-1:0] wc1;
   } s1_type;

   typedef struct packed {
      logic                bg;
      logic [COORD_W-1:0]  row;
      logic [COORD_W-1:0]  col;
      logic [WEIGHT_W-1:0] wr0;
      logic [WEIGHT_W-1:0] wr1;
   } s2_type;

endpackage

`default_nettype wire

// ----- sv/bilinear_displacement_warp.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Bilinear displacement warp over a banked image store.
// Input items: an item is taken at every rising edge with start high; busy is
// always low, so one item per cycle is accepted with no gaps.
//   operation 0 (load) writes req_pixel_in at (row, col) inside the grid; no result.
//   operation 1 (warp) blends the four stored neighbors of the displaced
//   position and gives one result (the background value if off the grid).
// Results: rsp_valid is high for one cycle with pixel_out, was_background and
// the echoed row and column. A warp's result passes through the stage-1,
// stage-2 and result registers; one result per cycle sustained.
// The store is split into four banks by row and column parity, so the four
// neighbors are read in the same cycle; the blend runs as three stages
// (memory read, horizontal blend, vertical blend and rounding).
// A load is visible to a warp accepted in the next cycle.
// The receiver cannot stall; results are never held.
// Configuration: csr_write_enable writes grid_rows (index 0) or grid_cols
// (index 1); write only while no warp is in flight.
// Reset: synchronous, clears the pipeline and sets both grid sizes to 29.
// Store contents are undefined until loaded; no clearing pass.
module bilinear_displacement_warp #(
   parameter int MAX_ROWS = bdw_pkg::DEFAULT_MAX_ROWS,
   parameter int MAX_COLS = bdw_pkg::DEFAULT_MAX_COLS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_operation,
   input  wire logic [bdw_pkg::COORD_W-1:0]          req_pixel_row,
   input  wire logic [bdw_pkg::COORD_W-1:0]          req_pixel_col,
   input  wire logic signed [bdw_pkg::PIXEL_W-1:0]   req_pixel_in,
   input  wire logic signed [bdw_pkg::SHIFT_W-1:0]   req_shift_vert,
   input  wire logic signed [bdw_pkg::SHIFT_W-1:0]   req_shift_horiz,
   output logic                                      rsp_valid,
   output logic signed [bdw_pkg::PIXEL_W-1:0]        rsp_pixel_out,
   output logic                                      rsp_was_background,
   output logic [bdw_pkg::COORD_W-1:0]               rsp_out_row,
   output logic [bdw_pkg::COORD_W-1:0]               rsp_out_col,
   input  wire logic                                 csr_write_enable,
   input  wire logic [bdw_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [bdw_pkg::GRID_W-1:0]           csr_write_data
);

   localparam int STORE_ROWS = (MAX_ROWS < bdw_pkg::COORD_SPAN) ? MAX_ROWS : bdw_pkg::COORD_SPAN;
   localparam int STORE_COLS = (MAX_COLS < bdw_pkg::COORD_SPAN) ? MAX_COLS : bdw_pkg::COORD_SPAN;
   localparam int BANK_ROWS  = (STORE_ROWS + 1) / 2;
   localparam int BANK_COLS  = (STORE_COLS + 1) / 2;
   localparam int BANK_DEPTH = BANK_ROWS * BANK_COLS;
   localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int INT_W      = bdw_pkg::SHIFT_W - bdw_pkg::FRAC_W;
   localparam int PAD_W      = bdw_pkg::BASE_W - INT_W;

   localparam logic [bdw_pkg::SIZE_W-1:0] MAX_ROWS_V = bdw_pkg::SIZE_W'(MAX_ROWS);
   localparam logic [bdw_pkg::SIZE_W-1:0] MAX_COLS_V = bdw_pkg::SIZE_W'(MAX_COLS);

   // configuration
   logic [bdw_pkg::GRID_W-1:0] grid_rows_ff;
   logic [bdw_pkg::GRID_W-1:0] grid_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= bdw_pkg::GRID_RESET;
         grid_cols_ff <= bdw_pkg::GRID_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bdw_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_write_data;
            bdw_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic [bdw_pkg::SIZE_W-1:0] grid_rows_ext;
   logic [bdw_pkg::SIZE_W-1:0] grid_cols_ext;
   logic [bdw_pkg::SIZE_W-1:0] rows_eff;
   logic [bdw_pkg::SIZE_W-1:0] cols_eff;

   assign grid_rows_ext = bdw_pkg::SIZE_W'(grid_rows_ff);
   assign grid_cols_ext = bdw_pkg::SIZE_W'(grid_cols_ff);
   assign rows_eff = (grid_rows_ext < MAX_ROWS_V) ? grid_rows_ext : MAX_ROWS_V;
   assign cols_eff = (grid_cols_ext < MAX_COLS_V) ? grid_cols_ext : MAX_COLS_V;

   // request decode
   logic accept;
   logic pos_in_grid;
   logic load_en;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign pos_in_grid = (bdw_pkg::SIZE_W'(req_pixel_row) < rows_eff) &&
                        (bdw_pkg::SIZE_W'(req_pixel_col) < cols_eff);
   assign load_en = accept && (req_operation == bdw_pkg::OP_LOAD) && pos_in_grid;

   logic [bdw_pkg::BASE_W-1:0] base_row;
   logic [bdw_pkg::BASE_W-1:0] base_col;
   logic [bdw_pkg::BASE_W-1:0] next_row;
   logic [bdw_pkg::BASE_W-1:0] next_col;
   logic                       hood_in_grid;

   assign base_row = bdw_pkg::BASE_W'(req_pixel_row) +
      {{PAD_W{req_shift_vert[bdw_pkg::SHIFT_W-1]}},
       req_shift_vert[bdw_pkg::SHIFT_W-1:bdw_pkg::FRAC_W]};
   assign base_col = bdw_pkg::BASE_W'(req_pixel_col) +
      {{PAD_W{req_shift_horiz[bdw_pkg::SHIFT_W-1]}},
       req_shift_horiz[bdw_pkg::SHIFT_W-1:bdw_pkg::FRAC_W]};
   assign next_row = base_row + bdw_pkg::BASE_W'(1);
   assign next_col = base_col + bdw_pkg::BASE_W'(1);
   assign hood_in_grid = !base_row[bdw_pkg::BASE_W-1] &&
                         (next_row < bdw_pkg::BASE_W'(rows_eff)) &&
                         !base_col[bdw_pkg::BASE_W-1] &&
                         (next_col < bdw_pkg::BASE_W'(cols_eff));

   // bank addressing: the neighbor pair always holds one even and one odd row
   logic [bdw_pkg::HALF_W-1:0] even_half_r;
   logic [bdw_pkg::HALF_W-1:0] odd_half_r;
   logic [bdw_pkg::HALF_W-1:0] even_half_c;
   logic [bdw_pkg::HALF_W-1:0] odd_half_c;

   assign odd_half_r  = base_row[bdw_pkg::COORD_W-1:1];
   assign even_half_r = base_row[bdw_pkg::COORD_W-1:1] + bdw_pkg::HALF_W'(base_row[0]);
   assign odd_half_c  = base_col[bdw_pkg::COORD_W-1:1];
   assign even_half_c = base_col[bdw_pkg::COORD_W-1:1] + bdw_pkg::HALF_W'(base_col[0]);

   logic [1:0]      wr_bank;
   logic [BA_W-1:0] wr_addr;

   assign wr_bank = {req_pixel_row[0], req_pixel_col[0]};
   assign wr_addr = BA_W'(int'(req_pixel_row[bdw_pkg::COORD_W-1:1]) * BANK_COLS +
                          int'(req_pixel_col[bdw_pkg::COORD_W-1:1]));

   logic [BA_W-1:0]             rd_addr    [bdw_pkg::BANKS];
   logic [bdw_pkg::PIXEL_W-1:0] rd_data_ff [bdw_pkg::BANKS];

   for (genvar b = 0; b < bdw_pkg::BANKS; b++) begin : g_bank
      localparam bit ROW_ODD = ((b >> 1) & 1) == 1;
      localparam bit COL_ODD = (b & 1) == 1;

      logic [bdw_pkg::PIXEL_W-1:0] bank_mem [BANK_DEPTH];
      logic [bdw_pkg::HALF_W-1:0]  half_r;
      logic [bdw_pkg::HALF_W-1:0]  half_c;

      assign half_r = ROW_ODD ? odd_half_r : even_half_r;
      assign half_c = COL_ODD ? odd_half_c : even_half_c;
      assign rd_addr[b] = BA_W'(int'(half_r) * BANK_COLS + int'(half_c));

      always_ff @(posedge clock) begin
         if (load_en && (wr_bank == 2'(b))) begin
            bank_mem[wr_addr] <= req_pixel_in;
         end
         rd_data_ff[b] <= bank_mem[rd_addr[b]];
      end
   end

   // stage 1: weights alongside the bank reads
   bdw_pkg::s1_type s1_in;
   bdw_pkg::s1_type s1_ff;
   logic            s1_valid_ff;
   logic [bdw_pkg::FRAC_W-1:0] frac_r;
   logic [bdw_pkg::FRAC_W-1:0] frac_c;

   assign frac_r = req_shift_vert[bdw_pkg::FRAC_W-1:0];
   assign frac_c = req_shift_horiz[bdw_pkg::FRAC_W-1:0];

   always_comb begin
      s1_in.bg      = !(pos_in_grid && hood_in_grid);
      s1_in.row     = req_pixel_row;
      s1_in.col     = req_pixel_col;
      s1_in.row_par = base_row[0];
      s1_in.col_par = base_col[0];
      s1_in.wr0     = bdw_pkg::ONE_Q8 - bdw_pkg::WEIGHT_W'(frac_r);
      s1_in.wr1     = bdw_pkg::WEIGHT_W'(frac_r);
      s1_in.wc0     = bdw_pkg::ONE_Q8 - bdw_pkg::WEIGHT_W'(frac_c);
      s1_in.wc1     = bdw_pkg::WEIGHT_W'(frac_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && (req_operation == bdw_pkg::OP_WARP);
      end
      s1_ff <= s1_in;
   end

   // stage 2: horizontal blend of the top and bottom pairs
   logic [bdw_pkg::PIXEL_W-1:0] pix_tl;
   logic [bdw_pkg::PIXEL_W-1:0] pix_tr;
   logic [bdw_pkg::PIXEL_W-1:0] pix_bl;
   logic [bdw_pkg::PIXEL_W-1:0] pix_br;

   assign pix_tl = rd_data_ff[{s1_ff.row_par, s1_ff.col_par}];
   assign pix_tr = rd_data_ff[{s1_ff.row_par, !s1_ff.col_par}];
   assign pix_bl = rd_data_ff[{!s1_ff.row_par, s1_ff.col_par}];
   assign pix_br = rd_data_ff[{!s1_ff.row_par, !s1_ff.col_par}];

   localparam int HPAD_P = bdw_pkg::HSUM_W - bdw_pkg::PIXEL_W;
   localparam int HPAD_W = bdw_pkg::HSUM_W - bdw_pkg::WEIGHT_W;

   logic [bdw_pkg::HSUM_W-1:0] wc0_ext;
   logic [bdw_pkg::HSUM_W-1:0] wc1_ext;
   logic [bdw_pkg::HSUM_W-1:0] top_in;
   logic [bdw_pkg::HSUM_W-1:0] bot_in;
   logic [bdw_pkg::HSUM_W-1:0] top_ff;
   logic [bdw_pkg::HSUM_W-1:0] bot_ff;
   bdw_pkg::s2_type            s2_in;
   bdw_pkg::s2_type            s2_ff;
   logic                       s2_valid_ff;

   assign wc0_ext = {{HPAD_W{1'b0}}, s1_ff.wc0};
   assign wc1_ext = {{HPAD_W{1'b0}}, s1_ff.wc1};
   assign top_in = {{HPAD_P{pix_tl[bdw_pkg::PIXEL_W-1]}}, pix_tl} * wc0_ext +
                   {{HPAD_P{pix_tr[bdw_pkg::PIXEL_W-1]}}, pix_tr} * wc1_ext;
   assign bot_in = {{HPAD_P{pix_bl[bdw_pkg::PIXEL_W-1]}}, pix_bl} * wc0_ext +
                   {{HPAD_P{pix_br[bdw_pkg::PIXEL_W-1]}}, pix_br} * wc1_ext;

   always_comb begin
      s2_in.bg  = s1_ff.bg;
      s2_in.row = s1_ff.row;
      s2_in.col = s1_ff.col;
      s2_in.wr0 = s1_ff.wr0;
      s2_in.wr1 = s1_ff.wr1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_ff  <= s2_in;
      top_ff <= top_in;
      bot_ff <= bot_in;
   end

   // stage 3: vertical blend, round half up, result register
   localparam int VPAD_H = bdw_pkg::VSUM_W - bdw_pkg::HSUM_W;
   localparam int VPAD_W = bdw_pkg::VSUM_W - bdw_pkg::WEIGHT_W;

   logic [bdw_pkg::VSUM_W-1:0] vsum;
   logic                       rsp_valid_ff;
   logic [bdw_pkg::PIXEL_W-1:0] rsp_pixel_out_ff;
   logic [bdw_pkg::PIXEL_W-1:0] rsp_pixel_out_in;
   logic                       rsp_was_background_ff;
   logic [bdw_pkg::COORD_W-1:0] rsp_out_row_ff;
   logic [bdw_pkg::COORD_W-1:0] rsp_out_col_ff;

   assign vsum = {{VPAD_H{top_ff[bdw_pkg::HSUM_W-1]}}, top_ff} *
                 {{VPAD_W{1'b0}}, s2_ff.wr0} +
                 {{VPAD_H{bot_ff[bdw_pkg::HSUM_W-1]}}, bot_ff} *
                 {{VPAD_W{1'b0}}, s2_ff.wr1} +
                 bdw_pkg::ROUND_HALF;
   assign rsp_pixel_out_in = s2_ff.bg ? bdw_pkg::BACKGROUND :
                             vsum[bdw_pkg::VSUM_W-1 -: bdw_pkg::PIXEL_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
      rsp_pixel_out_ff      <= rsp_pixel_out_in;
      rsp_was_background_ff <= s2_ff.bg;
      rsp_out_row_ff        <= s2_ff.row;
      rsp_out_col_ff        <= s2_ff.col;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_out      = rsp_pixel_out_ff;
   assign rsp_was_background = rsp_was_background_ff;
   assign rsp_out_row        = rsp_out_row_ff;
   assign rsp_out_col        = rsp_out_col_ff;

`ifndef SYNTH
   a_warp_gives_result: assert property (@(posedge clock)
      (accept && (req_operation == bdw_pkg::OP_WARP) && !reset) ##1 !reset ##1 !reset
      |=> rsp_valid)
      else $error("warp item lost its result");

   a_result_from_warp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept && (req_operation == bdw_pkg::OP_WARP), 3))
      else $error("result without a warp item");

   a_outside_is_background: assert property (@(posedge clock)
      (accept && (req_operation == bdw_pkg::OP_WARP) && !pos_in_grid && !reset)
      ##1 !reset ##1 !reset
      |=> (rsp_was_background && (rsp_pixel_out == bdw_pkg::BACKGROUND)))
      else $error("warp outside grid did not give background");

   a_position_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_out_row == $past(req_pixel_row, 3)) &&
                     (rsp_out_col == $past(req_pixel_col, 3))))
      else $error("echoed position does not match the warp item");
`endif

endmodule

`default_nettype wire
